FILE: rtl/socks5_udp_header_parser_macros.svh
// Assertion macros for the SOCKS5 UDP header parser.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SOCKS5_UDP_HEADER_PARSER_MACROS_SVH
`define SOCKS5_UDP_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define S5UDP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("s5udp: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define S5UDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("s5udp: next-cycle check failed");

`endif

FILE: rtl/s5udp_pkg.sv
// Shared types and constants for the SOCKS5 UDP header parser.
// No dependencies; used by the step logic and the top level.
`default_nettype none

package s5udp_pkg;

	// Address type codes carried in the fourth header byte.
	localparam logic [7:0] ATYP_IPV4   = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN = 8'h03;
	localparam logic [7:0] ATYP_IPV6   = 8'h04;

	localparam logic [7:0] LEN_IPV4 = 8'd4;
	localparam logic [7:0] LEN_IPV6 = 8'd16;

	// Parser phases.
	localparam logic [3:0] PH_RSV0    = 4'd0;
	localparam logic [3:0] PH_RSV1    = 4'd1;
	localparam logic [3:0] PH_FRAG    = 4'd2;
	localparam logic [3:0] PH_ATYP    = 4'd3;
	localparam logic [3:0] PH_V4      = 4'd4;
	localparam logic [3:0] PH_V6      = 4'd5;
	localparam logic [3:0] PH_DLEN    = 4'd6;
	localparam logic [3:0] PH_DCHAR   = 4'd7;
	localparam logic [3:0] PH_PORT_HI = 4'd8;
	localparam logic [3:0] PH_PORT_LO = 4'd9;
	localparam logic [3:0] PH_PAYLOAD = 4'd10;
	localparam logic [3:0] PH_DISCARD = 4'd11;

	// Byte roles reported with each result item.
	localparam logic [2:0] ROLE_FIXED   = 3'd0;
	localparam logic [2:0] ROLE_V4      = 3'd1;
	localparam logic [2:0] ROLE_V6      = 3'd2;
	localparam logic [2:0] ROLE_DLEN    = 3'd3;
	localparam logic [2:0] ROLE_DCHAR   = 3'd4;
	localparam logic [2:0] ROLE_PORT    = 3'd5;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd6;
	localparam logic [2:0] ROLE_DISCARD = 3'd7;

	// Datagram verdicts.
	localparam logic [1:0] VERDICT_PENDING  = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
	localparam logic [1:0] VERDICT_REJECTED = 2'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  byte_role;
		logic [7:0]  field_index;
		logic [15:0] dest_port;
		logic        end_of_packet;
		logic [1:0]  verdict;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [7:0]  field_count;
		logic [7:0]  domain_length;
		logic [15:0] port_accum;
		logic        reject_flag;
	} parse_state_t;

endpackage

`default_nettype wire

FILE: rtl/s5udp_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance, normally a struct from s5udp_pkg.
`default_nettype none

interface s5udp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/s5udp_step.sv
// Next-state and result logic of the header parser for one input byte.
// Depends on s5udp_pkg for the state, item types and phase and role codes.
`default_nettype none

module s5udp_step (
	input  s5udp_pkg::parse_state_t cur,
	input  s5udp_pkg::in_item_t     item,
	output s5udp_pkg::parse_state_t nxt,
	output s5udp_pkg::out_item_t    result
);
	import s5udp_pkg::*;

	logic [7:0]   cnt_inc;
	logic [2:0]   role;
	logic [7:0]   idx;
	parse_state_t upd;

	assign cnt_inc = cur.field_count + 8'd1;

	always_comb begin
		upd  = cur;
		role = ROLE_DISCARD;
		idx  = '0;
		unique case (cur.phase)
			PH_RSV0, PH_RSV1, PH_FRAG: begin
				role = ROLE_FIXED;
				if (item.byte_value != 8'd0) begin
					upd.reject_flag = 1'b1;
					upd.phase       = PH_DISCARD;
				end else begin
					upd.phase = cur.phase + 4'd1;
				end
			end
			PH_ATYP: begin
				role            = ROLE_FIXED;
				upd.field_count = '0;
				priority if (item.byte_value == ATYP_IPV4) begin
					upd.phase = PH_V4;
				end else if (item.byte_value == ATYP_IPV6) begin
					upd.phase = PH_V6;
				end else if (item.byte_value == ATYP_DOMAIN) begin
					upd.phase = PH_DLEN;
				end else begin
					upd.reject_flag = 1'b1;
					upd.phase       = PH_DISCARD;
				end
			end
			PH_V4: begin
				role            = ROLE_V4;
				idx             = cur.field_count;
				upd.field_count = cnt_inc;
				if (cnt_inc >= LEN_IPV4) begin
					upd.phase = PH_PORT_HI;
				end
			end
			PH_V6: begin
				role            = ROLE_V6;
				idx             = cur.field_count;
				upd.field_count = cnt_inc;
				if (cnt_inc >= LEN_IPV6) begin
					upd.phase = PH_PORT_HI;
				end
			end
			PH_DLEN: begin
				role              = ROLE_DLEN;
				upd.domain_length = item.byte_value;
				upd.field_count   = '0;
				upd.phase = (item.byte_value == 8'd0) ? PH_PORT_HI : PH_DCHAR;
			end
			PH_DCHAR: begin
				role            = ROLE_DCHAR;
				idx             = cur.field_count;
				upd.field_count = cnt_inc;
				if (cnt_inc >= cur.domain_length) begin
					upd.phase = PH_PORT_HI;
				end
			end
			PH_PORT_HI: begin
				role           = ROLE_PORT;
				upd.port_accum = {item.byte_value, 8'd0};
				upd.phase      = PH_PORT_LO;
			end
			PH_PORT_LO: begin
				role           = ROLE_PORT;
				upd.port_accum = {cur.port_accum[15:8], cur.port_accum[7:0] | item.byte_value};
				upd.phase      = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				role = ROLE_PAYLOAD;
			end
			default: begin
				role      = ROLE_DISCARD;
				upd.phase = PH_DISCARD;
			end
		endcase
	end

	always_comb begin
		result.out_byte      = item.byte_value;
		result.byte_role     = role;
		result.field_index   = idx;
		result.dest_port     = upd.port_accum;
		result.end_of_packet = item.is_last;
		result.verdict       = VERDICT_PENDING;
		nxt                  = upd;
		if (item.is_last) begin
			result.verdict = (!upd.reject_flag && upd.phase == PH_PAYLOAD) ?
				VERDICT_ACCEPTED : VERDICT_REJECTED;
			// The final byte closes the datagram; the next byte starts a new one.
			nxt.phase         = PH_RSV0;
			nxt.field_count   = '0;
			nxt.domain_length = '0;
			nxt.port_accum    = '0;
			nxt.reject_flag   = 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/socks5_udp_header_parser.sv
// SOCKS5 UDP request header parser: one datagram byte in, one tagged result item out.
// Latency: the result item for a byte is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless result_ch stalls; parser state and result register
// both update in the cycle of acceptance, so the single state-update path sets the rate.
// Reset (arst_n low, asynchronous): parser returns to the first reserved byte, the result
// register is emptied. Depends on s5udp_pkg, s5udp_chan_if, s5udp_step and the macros header.
`default_nettype none
`include "socks5_udp_header_parser_macros.svh"

module socks5_udp_header_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	s5udp_chan_if.sink          byte_ch,
	s5udp_chan_if.source        result_ch
);
	import s5udp_pkg::*;

	// Parser state, held between bytes of the same datagram. It returns to its
	// reset value after the byte flagged as last, so datagrams never interact.
	parse_state_t state_q;
	parse_state_t state_nxt;

	// Result register. It doubles as the output stage: a new byte is taken
	// whenever the register is empty or its item is being taken this cycle,
	// so a steady stream with result_ch ready runs at one byte per cycle with no bubbles.
	out_item_t result_q;
	out_item_t result_nxt;
	logic      result_valid_q;

	logic accept;

	assign byte_ch.ready = !result_valid_q || result_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	// All per-byte decisions: phase walk, address indexing, port assembly
	// and the final verdict for the datagram.
	s5udp_step u_step (
		.cur    (state_q),
		.item   (byte_ch.payload),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_RSV0;
			state_q.field_count   <= '0;
			state_q.domain_length <= '0;
			state_q.port_accum    <= '0;
			state_q.reject_flag   <= 1'b0;
			result_valid_q        <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload only; its content is qualified by result_valid_q.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nxt;
		end
	end

	assign result_ch.valid   = result_valid_q;
	assign result_ch.payload = result_q;

	// A verdict appears exactly on the item that ends a datagram.
	`S5UDP_ASSERT_NOW(a_verdict_on_eop, result_valid_q,
		(result_q.verdict != VERDICT_PENDING) == result_q.end_of_packet)
	// The final byte always leaves the parser ready for a fresh datagram.
	`S5UDP_ASSERT_NEXT(a_clear_after_last, accept && byte_ch.payload.is_last,
		state_q.phase == PH_RSV0 && !state_q.reject_flag && state_q.port_accum == 16'd0)
	// A rejected datagram is only ever in the discard phase.
	`S5UDP_ASSERT_NOW(a_reject_discards, state_q.reject_flag, state_q.phase == PH_DISCARD)
	// Every accepted byte produces a result item in the following cycle.
	`S5UDP_ASSERT_NEXT(a_result_follows, accept, result_valid_q)

endmodule

`default_nettype wire
